### design/assert_macros.svh
// Assertion helpers shared by the RTL. Every property is sampled on the rising
// edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside of reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checks that a condition never becomes true outside of reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

### design/i2cm_pkg.sv
package i2cm_pkg;

  // Default width of the phase delay counter.
  localparam int unsigned DELAY_BITS_DEFAULT = 16;

  // Phase length after reset, in words (ticks of the time base).
  localparam logic [15:0] HALF_DELAY_RESET = 16'd35;

  // Number of data bits in one transfer.
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] func;
    logic [7:0] write_byte;
    logic       send_nack;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       no_ack;
  } out_word_t;

  // Sequencer state carried from one word to the next.
  typedef struct packed {
    cmd_e       cmd;
    logic       active;
    logic [1:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] shreg;
    logic       ack;
    logic       scl;
    logic       sda;
    logic       drv;
    logic [7:0] last_read;
    logic       last_nack;
  } seq_state_t;

  localparam seq_state_t SEQ_RESET = '{
    cmd:       CMD_START,
    active:    1'b0,
    phase:     2'd0,
    bit_idx:   4'd0,
    shreg:     8'd0,
    ack:       1'b0,
    scl:       1'b1,
    sda:       1'b1,
    drv:       1'b1,
    last_read: 8'd0,
    last_nack: 1'b0
  };

endpackage

### design/i2cm_timer.sv
module i2cm_timer
  import i2cm_pkg::*;
#(
  parameter int unsigned DELAY_BITS = DELAY_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [15:0] half_delay_i,
  output logic        phase_end_o
);

  // Compare width wide enough for both the register and the counter.
  localparam int unsigned HW = (DELAY_BITS > 16) ? DELAY_BITS : 16;

  logic [DELAY_BITS-1:0] cnt_q;
  logic [DELAY_BITS-1:0] cnt_d;
  logic [DELAY_BITS-1:0] cnt_inc;
  logic [HW-1:0]         hd_ext;
  logic [HW-1:0]         mask_ext;
  logic [HW-1:0]         hd_sat;

  assign cnt_inc  = cnt_q + 1'b1;
  assign hd_ext   = HW'(half_delay_i);
  assign mask_ext = HW'({DELAY_BITS{1'b1}});

  // A zero length counts as one; a length the counter cannot reach is clipped.
  always_comb begin
    hd_sat = (hd_ext > mask_ext) ? mask_ext : hd_ext;
    if (hd_sat == '0) begin
      hd_sat = HW'(1);
    end
  end

  assign phase_end_o = (HW'(cnt_inc) >= hd_sat);
  assign cnt_d       = phase_end_o ? '0 : cnt_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### design/i2cm_seq.sv
module i2cm_seq
  import i2cm_pkg::*;
(
  input  seq_state_t cur_i,
  input  in_word_t   word_i,
  input  logic       phase_end_i,
  output seq_state_t nxt_o,
  output out_word_t  res_o
);

  // Pin levels {scl, sda, drive} shown on entry to the phase that s points at.
  function automatic logic [2:0] phase_pins(input seq_state_t s);
    logic [2:0] p;
    logic       data_phase;
    data_phase = (s.bit_idx < BYTE_BITS);
    case (s.cmd)
      CMD_START: begin
        if (s.phase == 2'd0) begin
          p = 3'b111;
        end else if (s.phase == 2'd1) begin
          p = 3'b101;
        end else begin
          p = 3'b001;
        end
      end
      CMD_STOP: begin
        if (s.phase == 2'd0) begin
          p = 3'b001;
        end else if (s.phase == 2'd1) begin
          p = 3'b101;
        end else begin
          p = 3'b111;
        end
      end
      CMD_WRITE: begin
        if (data_phase) begin
          p = {s.phase == 2'd1, s.shreg[7], 1'b1};
        end else begin
          p = {s.phase == 2'd1, 1'b1, 1'b0};
        end
      end
      CMD_READ: begin
        if (data_phase) begin
          p = {s.phase == 2'd0, 1'b1, 1'b0};
        end else begin
          p = {s.phase == 2'd1, s.ack, 1'b1};
        end
      end
      default: begin
        p = 3'b111;
      end
    endcase
    return p;
  endfunction

  seq_state_t nxt;
  logic       enter;
  logic       done;
  logic       data_phase;

  assign data_phase = (cur_i.bit_idx < BYTE_BITS);

  always_comb begin
    nxt   = cur_i;
    enter = 1'b0;
    done  = 1'b0;
    if (!cur_i.active) begin
      if (word_i.cmd_valid) begin
        nxt.cmd     = cmd_e'(word_i.func);
        nxt.shreg   = (cmd_e'(word_i.func) == CMD_WRITE) ? word_i.write_byte : 8'd0;
        nxt.ack     = word_i.send_nack;
        nxt.active  = 1'b1;
        nxt.phase   = 2'd0;
        nxt.bit_idx = 4'd0;
        enter       = 1'b1;
      end
    end else if (phase_end_i) begin
      enter = 1'b1;
      case (cur_i.cmd)
        CMD_START, CMD_STOP: begin
          if (cur_i.phase < 2'd2) begin
            nxt.phase = cur_i.phase + 2'd1;
          end else begin
            done = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (data_phase) begin
            if (cur_i.phase < 2'd2) begin
              nxt.phase = cur_i.phase + 2'd1;
            end else begin
              nxt.shreg   = {cur_i.shreg[6:0], 1'b0};
              nxt.bit_idx = cur_i.bit_idx + 4'd1;
              nxt.phase   = 2'd0;
            end
          end else if (cur_i.phase == 2'd0) begin
            nxt.phase = 2'd1;
          end else begin
            // Acknowledge sampled; SCL falls and SDA stays released.
            nxt.last_nack = word_i.sda_in;
            nxt.scl       = 1'b0;
            nxt.sda       = 1'b1;
            nxt.drv       = 1'b0;
            done          = 1'b1;
          end
        end
        CMD_READ: begin
          if (data_phase) begin
            if (cur_i.phase == 2'd0) begin
              nxt.shreg = {cur_i.shreg[6:0], word_i.sda_in};
              nxt.phase = 2'd1;
            end else begin
              nxt.bit_idx = cur_i.bit_idx + 4'd1;
              nxt.phase   = 2'd0;
            end
          end else if (cur_i.phase < 2'd2) begin
            nxt.phase = cur_i.phase + 2'd1;
          end else begin
            nxt.last_read = cur_i.shreg;
            done          = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        enter       = 1'b0;
        nxt.active  = 1'b0;
        nxt.phase   = 2'd0;
        nxt.bit_idx = 4'd0;
      end
    end
    if (enter) begin
      {nxt.scl, nxt.sda, nxt.drv} = phase_pins(nxt);
    end
  end

  assign nxt_o = nxt;

  always_comb begin
    res_o.scl       = nxt.scl;
    res_o.sda_out   = nxt.sda;
    res_o.sda_drive = nxt.drv;
    res_o.busy_res  = nxt.active;
    res_o.done_res  = done;
    res_o.read_byte = nxt.last_read;
    res_o.no_ack    = nxt.last_nack;
  end

endmodule

### design/i2c_master_byte_engine_core.sv
// Channel  Direction  Valid        Stall        Payload
// input    in         in_valid_i   in_stall_o   in_word_i  (in_word_t)
// output   out        out_valid_o  out_stall_i  out_word_o (out_word_t)
// config   in         cfg_we_i     -            cfg_wdata_i (half_delay)
//
// The core takes one word per clock cycle while neither side stalls, and
// returns one result word for it. Each word is one tick of the I2C time base;
// it is held in the input register, passes through the single step of
// sequencer logic and is held in the result register.
// Reset leaves the sequencer state with SCL and SDA driven high, the core idle
// and the phase length register at 35.
// A stall on the output holds the result register; the input register then
// fills and the input stall rises in the same cycle, so no word is lost.
module i2c_master_byte_engine_core
  import i2cm_pkg::*;
#(
  parameter int unsigned DELAY_BITS = DELAY_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

`include "assert_macros.svh"

  // Input register: holds the next word until the sequencer steps on it.
  logic       in_vld_q;
  in_word_t   in_q;

  // Result register: holds the last result until the receiver takes it.
  logic       out_vld_q;
  out_word_t  out_q;

  // Sequencer state and the phase length register.
  seq_state_t state_q;
  seq_state_t state_d;
  logic [15:0] half_delay_q;

  out_word_t  res;
  logic       advance;
  logic       phase_end;

  // The sequencer steps whenever a word waits and the result register has room.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  // The phase timer runs only while a command is in progress, one count per word.
  i2cm_timer #(
    .DELAY_BITS(DELAY_BITS)
  ) u_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance && state_q.active),
    .half_delay_i(half_delay_q),
    .phase_end_o (phase_end)
  );

  // Command decode, phase stepping and pin levels for one word.
  i2cm_seq u_seq (
    .cur_i      (state_q),
    .word_i     (in_q),
    .phase_end_i(phase_end),
    .nxt_o      (state_d),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // The payload register needs no reset; it loads with every accepted word.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Configuration must be written only while the core is idle; it is not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_delay_q <= HALF_DELAY_RESET;
    end else if (cfg_we_i) begin
      half_delay_q <= cfg_wdata_i;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // A completion can only come from a command that was running.
  `ASSERT_CLK(a_done_from_active, (advance && res.done_res) |-> state_q.active)
  // The bit counter never runs past the acknowledge slot.
  `ASSERT_NEVER(a_bit_idx_range, state_q.bit_idx > BYTE_BITS)
  // The input side stalls only when the result register is full and held.
  `ASSERT_CLK(a_stall_cause, in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
  // A finished write leaves SDA released for the slave.
  `ASSERT_CLK(a_write_release,
              (advance && res.done_res && state_q.cmd == CMD_WRITE) |=> !out_q.sda_drive)

endmodule

### tb/tb_i2c_master_byte_engine_core.sv
module tb_i2c_master_byte_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // Clock, reset and the signals on both channels. Every input of the core
  // starts at a known level.
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;

  i2c_master_byte_engine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Words waiting to be offered, and the result words that the pin sequencer
  // model says must come back, oldest first.
  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  out_word_t want_word;

  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Words put on the bus by the sender and words checked by the receiver.
  int words_sent    = 0;
  int words_checked = 0;

  // The receiver serves long hold-off requests in its own process.
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;

  // Pin sequencer model state, including its own copy of the phase length.
  cmd_e        mdl_cmd;
  logic        mdl_active;
  logic [1:0]  mdl_phase;
  logic [3:0]  mdl_bit;
  logic [15:0] mdl_count;
  logic [7:0]  mdl_shift;
  logic        mdl_ack;
  logic        mdl_scl;
  logic        mdl_sda;
  logic        mdl_drv;
  logic [7:0]  mdl_last_read;
  logic        mdl_last_nack;
  logic [15:0] mdl_half_delay;

  // Sets the pins of the phase that the sequencer has just entered.
  function automatic void load_phase_pins();
    case (mdl_cmd)
      CMD_START: begin
        mdl_scl = (mdl_phase != 2'd2);
        mdl_sda = (mdl_phase == 2'd0);
        mdl_drv = 1'b1;
      end
      CMD_STOP: begin
        mdl_scl = (mdl_phase != 2'd0);
        mdl_sda = (mdl_phase == 2'd2);
        mdl_drv = 1'b1;
      end
      CMD_WRITE: begin
        // SCL is high only in the middle phase, so the data bit is stable
        // while SCL is high. The acknowledge slot releases SDA.
        mdl_scl = (mdl_phase == 2'd1);
        mdl_sda = (mdl_bit < BYTE_BITS) ? mdl_shift[7] : 1'b1;
        mdl_drv = (mdl_bit < BYTE_BITS);
      end
      default: begin
        if (mdl_bit < BYTE_BITS) begin
          mdl_scl = (mdl_phase == 2'd0);
          mdl_sda = 1'b1;
          mdl_drv = 1'b0;
        end else begin
          mdl_scl = (mdl_phase == 2'd1);
          mdl_sda = mdl_ack;
          mdl_drv = 1'b1;
        end
      end
    endcase
  endfunction

  // Ends the current phase and returns 1 when the command is complete.
  function automatic logic finish_phase(logic sda_level);
    logic last;
    last = 1'b0;
    case (mdl_cmd)
      CMD_START, CMD_STOP: begin
        if (mdl_phase < 2'd2) mdl_phase = mdl_phase + 2'd1;
        else last = 1'b1;
      end
      CMD_WRITE: begin
        if (mdl_bit < BYTE_BITS) begin
          if (mdl_phase < 2'd2) begin
            mdl_phase = mdl_phase + 2'd1;
          end else begin
            mdl_shift = {mdl_shift[6:0], 1'b0};
            mdl_bit   = mdl_bit + 4'd1;
            mdl_phase = 2'd0;
          end
        end else if (mdl_phase == 2'd0) begin
          mdl_phase = 2'd1;
        end else begin
          // The level sampled at the end of the acknowledge slot is the
          // no-acknowledge flag; SCL drops with SDA still released.
          mdl_last_nack = sda_level;
          mdl_scl       = 1'b0;
          mdl_sda       = 1'b1;
          mdl_drv       = 1'b0;
          last          = 1'b1;
        end
      end
      default: begin
        if (mdl_bit < BYTE_BITS) begin
          if (mdl_phase == 2'd0) begin
            mdl_shift = {mdl_shift[6:0], sda_level};
            mdl_phase = 2'd1;
          end else begin
            mdl_bit   = mdl_bit + 4'd1;
            mdl_phase = 2'd0;
          end
        end else if (mdl_phase < 2'd2) begin
          mdl_phase = mdl_phase + 2'd1;
        end else begin
          mdl_last_read = mdl_shift;
          last          = 1'b1;
        end
      end
    endcase
    return last;
  endfunction

  // Advances the model by one tick and returns the result word for it.
  function automatic out_word_t sequence_tick(in_word_t w);
    out_word_t   r;
    logic [15:0] span;
    logic        completed;
    completed = 1'b0;
    if (!mdl_active) begin
      // A command is taken only while idle, and the accepting tick already
      // shows the pins of the first phase.
      if (w.cmd_valid) begin
        mdl_cmd    = cmd_e'(w.func);
        mdl_shift  = (mdl_cmd == CMD_WRITE) ? w.write_byte : 8'd0;
        mdl_ack    = w.send_nack;
        mdl_active = 1'b1;
        mdl_phase  = 2'd0;
        mdl_bit    = 4'd0;
        mdl_count  = 16'd0;
        load_phase_pins();
      end
    end else begin
      // A phase length of zero behaves as one.
      span      = (mdl_half_delay == 16'd0) ? 16'd1 : mdl_half_delay;
      mdl_count = mdl_count + 16'd1;
      if (mdl_count >= span) begin
        mdl_count = 16'd0;
        if (finish_phase(w.sda_in)) begin
          mdl_active = 1'b0;
          mdl_phase  = 2'd0;
          mdl_bit    = 4'd0;
          completed  = 1'b1;
        end else begin
          load_phase_pins();
        end
      end
    end
    r.scl       = mdl_scl;
    r.sda_out   = mdl_sda;
    r.sda_drive = mdl_drv;
    r.busy_res  = mdl_active;
    r.done_res  = completed;
    r.read_byte = mdl_last_read;
    r.no_ack    = mdl_last_nack;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
  endtask

  // Sender. A word that is offered stays on the bus, unchanged, until it is
  // taken; only then is the next one picked or a gap inserted. The model is
  // stepped once for every word that the core accepts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) begin
          expected_words.push_back(sequence_tick(in_word));
        end
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word    <= pending_words.pop_front();
          in_valid   <= 1'b1;
          words_sent = words_sent + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each word taken is checked field by field against the oldest
  // expected word. Then the stall for the next cycle is picked, either from a
  // pending long hold-off or at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        words_checked = words_checked + 1;
        if (expected_words.size() == 0) begin
          flag_mismatch("word with nothing expected", int'(out_word), 0);
        end else begin
          want_word = expected_words.pop_front();
          if (out_word.scl !== want_word.scl)
            flag_mismatch("scl", int'(out_word.scl), int'(want_word.scl));
          if (out_word.sda_out !== want_word.sda_out)
            flag_mismatch("sda_out", int'(out_word.sda_out), int'(want_word.sda_out));
          if (out_word.sda_drive !== want_word.sda_drive)
            flag_mismatch("sda_drive", int'(out_word.sda_drive), int'(want_word.sda_drive));
          if (out_word.busy_res !== want_word.busy_res)
            flag_mismatch("busy_res", int'(out_word.busy_res), int'(want_word.busy_res));
          if (out_word.done_res !== want_word.done_res)
            flag_mismatch("done_res", int'(out_word.done_res), int'(want_word.done_res));
          if (out_word.read_byte !== want_word.read_byte)
            flag_mismatch("read_byte", int'(out_word.read_byte), int'(want_word.read_byte));
          if (out_word.no_ack !== want_word.no_ack)
            flag_mismatch("no_ack", int'(out_word.no_ack), int'(want_word.no_ack));
        end
      end
      if (hold_asks != hold_served) begin
        hold_served = hold_served + 1;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic in_word_t make_word(logic v, cmd_e f, logic [7:0] b, logic nack,
                                         logic sda);
    in_word_t w;
    w.cmd_valid  = v;
    w.func       = f;
    w.write_byte = b;
    w.send_nack  = nack;
    w.sda_in     = sda;
    return w;
  endfunction

  // Queues words with no command offered. The other fields are random so that
  // ignored content is exercised too; sda_mode 0 or 1 holds SDA at that
  // level, any other value makes it random.
  task automatic idle_ticks(int n, int sda_mode);
    logic sda;
    repeat (n) begin
      sda = (sda_mode < 2) ? sda_mode[0] : 1'($urandom_range(1));
      pending_words.push_back(make_word(1'b0, cmd_e'($urandom_range(3)),
                                        8'($urandom_range(255)),
                                        1'($urandom_range(1)), sda));
    end
  endtask

  task automatic issue(cmd_e f, logic [7:0] b, logic nack, int ticks, int sda_mode);
    pending_words.push_back(make_word(1'b1, f, b, nack, 1'($urandom_range(1))));
    idle_ticks(ticks, sda_mode);
  endtask

  // Random words: a command is offered in about one tick of three, so most
  // commands are taken soon after the previous one completes and some land
  // on busy or completion ticks.
  task automatic random_words(int n);
    repeat (n) begin
      pending_words.push_back(make_word($urandom_range(2) == 0, cmd_e'($urandom_range(3)),
                                        8'($urandom_range(255)), 1'($urandom_range(1)),
                                        1'($urandom_range(1))));
    end
  endtask

  // Waits until every queued word has been taken and checked. If the model
  // says a command is still running, idle ticks are added until it ends, so
  // the sequencer is idle too. The pause at the end covers the input and result
  // registers of the core.
  task automatic settle();
    forever begin
      while (pending_words.size() != 0 || words_checked != words_sent)
        @(posedge clk_i);
      if (!mdl_active) break;
      idle_ticks(64, 2);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_half_delay(logic [15:0] v);
    settle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we         <= 1'b0;
    mdl_half_delay = v;
  endtask

  initial begin
    // The model starts in its reset state: bus high and driven, core idle,
    // phase length at 35.
    mdl_cmd        = CMD_START;
    mdl_active     = 1'b0;
    mdl_phase      = 2'd0;
    mdl_bit        = 4'd0;
    mdl_count      = 16'd0;
    mdl_shift      = 8'd0;
    mdl_ack        = 1'b0;
    mdl_scl        = 1'b1;
    mdl_sda        = 1'b1;
    mdl_drv        = 1'b1;
    mdl_last_read  = 8'd0;
    mdl_last_nack  = 1'b0;
    mdl_half_delay = HALF_DELAY_RESET;

    // The sender idles a quarter of the time and the receiver most of it.
    send_idle_pct = 24;
    recv_idle_pct = 62;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A start condition with the phase length left at its reset value.
    issue(CMD_START, 8'h00, 1'b0, 120, 2);

    // Directed words at the shortest phase length: every command, all-ones
    // and all-zeros data, acknowledge and no-acknowledge on both sides.
    set_half_delay(16'd1);
    issue(CMD_START, 8'h00, 1'b0, 4, 2);
    issue(CMD_WRITE, 8'hFF, 1'b0, 28, 0);
    issue(CMD_WRITE, 8'h00, 1'b1, 28, 1);
    issue(CMD_WRITE, 8'hA5, 1'b0, 28, 2);
    issue(CMD_READ, 8'h00, 1'b1, 21, 1);
    issue(CMD_READ, 8'hFF, 1'b0, 21, 0);
    issue(CMD_READ, 8'h5A, 1'b1, 21, 2);
    // Commands offered while a write is running must be ignored.
    issue(CMD_WRITE, 8'h3C, 1'b0, 0, 2);
    issue(CMD_READ, 8'hC3, 1'b1, 0, 2);
    issue(CMD_STOP, 8'h81, 1'b0, 30, 2);
    // Back-to-back starts: the one offered in the completion tick is dropped
    // and the next one is taken.
    repeat (8) issue(CMD_START, 8'h00, 1'b0, 0, 2);
    issue(CMD_STOP, 8'h00, 1'b0, 4, 2);

    // Random words, with one long hold-off on the output while the sender
    // keeps offering, so the core fills up and stalls its input.
    random_words(350);
    while (pending_words.size() > 250) @(posedge clk_i);
    hold_asks = hold_asks + 1;

    set_half_delay(16'd2);
    send_idle_pct = 62;
    recv_idle_pct = 24;
    random_words(300);

    set_half_delay(16'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(200);

    set_half_delay(16'd3);
    random_words(150);

    // A long phase length, over one complete start condition.
    set_half_delay(16'd100);
    issue(CMD_START, 8'h00, 1'b0, 310, 2);

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // The slowest correct run ends well before this timeout, even with the
  // receiver holding off for long stretches.
  initial begin
    #200_000;
    $display("simulation failed");
    $finish;
  end

endmodule
